// File: rtl/cldec_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cldec_pkg
// Shared constants and types of the DEFLATE code-length decoder.
// ----------------------------------------------------------------------------
package cldec_pkg;

    localparam int MAX_CODE_BITS = 7;
    localparam int TABLE_SYMBOLS = 19;
    localparam int MAX_TOTAL     = 320;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 63;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 24;

    typedef struct packed {
        logic [8:0]  total;
        logic [56:0] lengths;
        logic [62:0] codes_low;
        logic [62:0] codes_mid;
        logic [6:0]  codes_high;
    } t_cfg;

    typedef struct packed {
        logic       hit;
        logic [4:0] sym;
    } t_match;

    typedef struct packed {
        logic       valid;
        logic [8:0] start;
        logic [3:0] value;
        logic [7:0] count;
        logic       error;
        logic       last;
    } t_run;

endpackage : cldec_pkg
`default_nettype wire

// File: rtl/cldec_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cldec_cfg_regs
// Configuration registers: total count and the code-length alphabet table.
// ----------------------------------------------------------------------------
module cldec_cfg_regs (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [cldec_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [cldec_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output cldec_pkg::t_cfg                        o_cfg
);
    import cldec_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] REG_TOTAL      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LENGTHS    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CODES_LOW  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CODES_MID  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_CODES_HIGH = 3'd4;

    localparam logic [8:0] TOTAL_LIMIT = 9'(MAX_TOTAL);

    logic [8:0]  r_total;
    logic [56:0] r_lengths;
    logic [62:0] r_codes_low;
    logic [62:0] r_codes_mid;
    logic [6:0]  r_codes_high;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total      <= 9'd1;
            r_lengths    <= '0;
            r_codes_low  <= '0;
            r_codes_mid  <= '0;
            r_codes_high <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_TOTAL:      r_total      <= i_cfg_data[8:0];
                REG_LENGTHS:    r_lengths    <= i_cfg_data[56:0];
                REG_CODES_LOW:  r_codes_low  <= i_cfg_data[62:0];
                REG_CODES_MID:  r_codes_mid  <= i_cfg_data[62:0];
                REG_CODES_HIGH: r_codes_high <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        o_cfg.total      = (r_total > TOTAL_LIMIT) ? TOTAL_LIMIT : r_total;
        o_cfg.lengths    = r_lengths;
        o_cfg.codes_low  = r_codes_low;
        o_cfg.codes_mid  = r_codes_mid;
        o_cfg.codes_high = r_codes_high;
    end

endmodule : cldec_cfg_regs
`default_nettype wire

// File: rtl/cldec_sym_match.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cldec_sym_match
// Parallel compare of a partial code against all 19 table entries.
// ----------------------------------------------------------------------------
module cldec_sym_match (
    input  wire cldec_pkg::t_cfg i_cfg,
    input  wire logic [6:0]      i_code,
    input  wire logic [2:0]      i_bits,
    output cldec_pkg::t_match    o_match
);
    import cldec_pkg::*;

    logic [TABLE_SYMBOLS-1:0] w_hit;

    for (genvar k = 0; k < TABLE_SYMBOLS; k++) begin : g_sym
        logic [2:0] w_len;
        logic [6:0] w_code;
        assign w_len = i_cfg.lengths[3*k +: 3];
        if (k < 9) begin : g_low
            assign w_code = i_cfg.codes_low[7*k +: 7];
        end else if (k < 18) begin : g_mid
            assign w_code = i_cfg.codes_mid[7*(k-9) +: 7];
        end else begin : g_high
            assign w_code = i_cfg.codes_high;
        end
        assign w_hit[k] = (w_len == i_bits) && (w_code == i_code);
    end

    always_comb begin
        o_match.hit = |w_hit;
        o_match.sym = '0;
        for (int k = TABLE_SYMBOLS - 1; k >= 0; k--) begin
            if (w_hit[k]) begin
                o_match.sym = 5'(k);
            end
        end
    end

endmodule : cldec_sym_match
`default_nettype wire

// File: rtl/cldec_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cldec_step
// Decoder state and the per-bit step from one registered item to a result.
// ----------------------------------------------------------------------------
module cldec_step (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_fire,
    input  wire logic            i_cmd,
    input  wire logic            i_bit,
    input  wire cldec_pkg::t_cfg i_cfg,
    output cldec_pkg::t_run      o_run
);
    import cldec_pkg::*;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_CODE  = 2'd1;
    localparam logic [1:0] PH_EXTRA = 2'd2;
    localparam logic [1:0] PH_ERROR = 2'd3;

    localparam logic [4:0] SYM_REPEAT = 5'd16;
    localparam logic [1:0] KIND_REPEAT     = 2'd0;
    localparam logic [1:0] KIND_ZERO_SHORT = 2'd1;
    localparam logic [2:0] CODE_BITS_LIMIT = 3'(MAX_CODE_BITS);

    logic [1:0] r_phase, n_phase;
    logic [6:0] r_code_accum, n_code_accum;
    logic [2:0] r_code_bits, n_code_bits;
    logic [1:0] r_run_kind, n_run_kind;
    logic [6:0] r_extra_accum, n_extra_accum;
    logic [2:0] r_extra_seen, n_extra_seen;
    logic [8:0] r_position, n_position;
    logic [3:0] r_previous_length, n_previous_length;

    logic [6:0] w_code_next;
    logic [2:0] w_bits_next;
    t_match     w_match;

    assign w_code_next = {r_code_accum[5:0], i_bit};
    assign w_bits_next = r_code_bits + 3'd1;

    cldec_sym_match u_match (
        .i_cfg   (i_cfg),
        .i_code  (w_code_next),
        .i_bits  (w_bits_next),
        .o_match (w_match)
    );

    logic [6:0] w_extra_next;
    logic [2:0] w_seen_next;
    logic [2:0] w_need;
    logic [7:0] w_repeat;
    logic [9:0] w_pos_end;
    logic [8:0] w_pos_inc;
    logic [3:0] w_value;

    always_comb begin
        w_extra_next = r_extra_accum | (7'(i_bit) << r_extra_seen);
        w_seen_next  = r_extra_seen + 3'd1;
        w_need       = (r_run_kind == KIND_REPEAT) ? 3'd2 :
                       (r_run_kind == KIND_ZERO_SHORT) ? 3'd3 : 3'd7;
        w_repeat     = {1'b0, w_extra_next} +
                       ((r_run_kind == KIND_REPEAT || r_run_kind == KIND_ZERO_SHORT) ?
                        8'd3 : 8'd11);
        w_pos_end    = {1'b0, r_position} + {2'b00, w_repeat};
        w_pos_inc    = r_position + 9'd1;
        w_value      = (r_run_kind == KIND_REPEAT) ? r_previous_length : 4'd0;
    end

    always_comb begin
        n_phase           = r_phase;
        n_code_accum      = r_code_accum;
        n_code_bits       = r_code_bits;
        n_run_kind        = r_run_kind;
        n_extra_accum     = r_extra_accum;
        n_extra_seen      = r_extra_seen;
        n_position        = r_position;
        n_previous_length = r_previous_length;
        o_run             = '0;
        o_run.start       = r_position;

        if (i_fire) begin
            if (!i_cmd) begin
                n_code_accum      = '0;
                n_code_bits       = '0;
                n_run_kind        = '0;
                n_extra_accum     = '0;
                n_extra_seen      = '0;
                n_position        = '0;
                n_previous_length = '0;
                n_phase           = (i_cfg.total == 9'd0) ? PH_IDLE : PH_CODE;
            end else begin
                unique case (r_phase)
                    PH_CODE: begin
                        if (!w_match.hit) begin
                            if (w_bits_next >= CODE_BITS_LIMIT) begin
                                n_phase     = PH_ERROR;
                                o_run.valid = 1'b1;
                                o_run.error = 1'b1;
                            end else begin
                                n_code_accum = w_code_next;
                                n_code_bits  = w_bits_next;
                            end
                        end else begin
                            n_code_accum = '0;
                            n_code_bits  = '0;
                            if (!w_match.sym[4]) begin
                                n_position        = w_pos_inc;
                                n_previous_length = w_match.sym[3:0];
                                o_run.valid       = 1'b1;
                                o_run.value       = w_match.sym[3:0];
                                o_run.count       = 8'd1;
                                o_run.last        = (w_pos_inc >= i_cfg.total);
                                if (w_pos_inc >= i_cfg.total) begin
                                    n_phase = PH_IDLE;
                                end
                            end else if (w_match.sym == SYM_REPEAT && r_position == 9'd0) begin
                                n_phase     = PH_ERROR;
                                o_run.valid = 1'b1;
                                o_run.error = 1'b1;
                            end else begin
                                n_run_kind    = 2'(w_match.sym - SYM_REPEAT);
                                n_extra_accum = '0;
                                n_extra_seen  = '0;
                                n_phase       = PH_EXTRA;
                            end
                        end
                    end
                    PH_EXTRA: begin
                        n_extra_accum = w_extra_next;
                        n_extra_seen  = w_seen_next;
                        if (w_seen_next >= w_need) begin
                            if (w_pos_end > {1'b0, i_cfg.total}) begin
                                n_phase     = PH_ERROR;
                                o_run.valid = 1'b1;
                                o_run.error = 1'b1;
                            end else begin
                                n_position        = w_pos_end[8:0];
                                n_previous_length = w_value;
                                n_extra_accum     = '0;
                                n_extra_seen      = '0;
                                n_run_kind        = '0;
                                o_run.valid       = 1'b1;
                                o_run.value       = w_value;
                                o_run.count       = w_repeat;
                                o_run.last        = (w_pos_end[8:0] >= i_cfg.total);
                                n_phase = (w_pos_end[8:0] >= i_cfg.total) ? PH_IDLE : PH_CODE;
                            end
                        end
                    end
                    PH_IDLE, PH_ERROR: ;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase           <= PH_IDLE;
            r_code_accum      <= '0;
            r_code_bits       <= '0;
            r_run_kind        <= '0;
            r_extra_accum     <= '0;
            r_extra_seen      <= '0;
            r_position        <= '0;
            r_previous_length <= '0;
        end else begin
            r_phase           <= n_phase;
            r_code_accum      <= n_code_accum;
            r_code_bits       <= n_code_bits;
            r_run_kind        <= n_run_kind;
            r_extra_accum     <= n_extra_accum;
            r_extra_seen      <= n_extra_seen;
            r_position        <= n_position;
            r_previous_length <= n_previous_length;
        end
    end

endmodule : cldec_step
`default_nettype wire

// File: rtl/deflate_code_length_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// Path: an input transaction is held in the input register; its result, if it makes one, is written
// to the result register when that register is free or its result is being taken.
// Throughput: one stream bit per cycle while the result side does not stall; the step logic between
// the input register and the result register takes one registered item in every cycle it is not stalled.
// Reset: synchronous, active low; clears the decoder to idle, the registers to their
// defaults (total count 1, table zero) and drops both valid flags.
// ----------------------------------------------------------------------------
// deflate_code_length_decoder
// Bit-serial decoder of the code-length stage of a dynamic Huffman header.
// ----------------------------------------------------------------------------
module deflate_code_length_decoder (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Input stream.
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    input  wire logic [cldec_pkg::S_TDATA_W-1:0]   i_s_tdata,  // [0] stream_bit
    input  wire logic                              i_s_tuser,  // [0] cmd
    // Result stream.
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    output logic [cldec_pkg::M_TDATA_W-1:0]        o_m_tdata,  // [8:0] run_start,
                                                               // [12:9] run_value,
                                                               // [20:13] run_count
    output logic                                   o_m_tuser,  // [0] error
    output logic                                   o_m_tlast,
    // Configuration writes.
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [cldec_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [cldec_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import cldec_pkg::*;

    t_cfg w_cfg;
    t_run w_run;

    logic r_in_valid;
    logic r_in_cmd;
    logic r_in_bit;
    logic w_advance;

    logic       r_out_valid;
    logic [8:0] r_out_start;
    logic [3:0] r_out_value;
    logic [7:0] r_out_count;
    logic       r_out_error;
    logic       r_out_last;

    cldec_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    assign w_advance  = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_cmd <= i_s_tuser;
            r_in_bit <= i_s_tdata[0];
        end
    end

    cldec_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_advance),
        .i_cmd   (r_in_cmd),
        .i_bit   (r_in_bit),
        .i_cfg   (w_cfg),
        .o_run   (w_run)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_run.valid;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_run.valid) begin
            r_out_start <= w_run.start;
            r_out_value <= w_run.value;
            r_out_count <= w_run.count;
            r_out_error <= w_run.error;
            r_out_last  <= w_run.last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_out_count, r_out_value, r_out_start};
    assign o_m_tuser  = r_out_error;
    assign o_m_tlast  = r_out_last;

endmodule : deflate_code_length_decoder
`default_nettype wire

// File: rtl/cldec_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cldec_checker
// Port-level checks of the code-length decoder, bound to the top level.
// ----------------------------------------------------------------------------
module cldec_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [23:0] o_m_tdata,
    input wire logic        o_m_tuser,
    input wire logic        o_m_tlast
);

    // An error transaction carries no entries and never closes the table.
    a_error_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata[20:13] == 8'd0 && !o_m_tlast)
        else $error("error transaction with nonzero count or last");

    // A good run holds between one and 138 entries.
    a_run_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata[20:13] != 8'd0 && o_m_tdata[20:13] <= 8'd138)
        else $error("run count out of range");

    // A run never starts beyond the largest table.
    a_run_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[8:0] < 9'd320)
        else $error("run start out of range");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("result changed while stalled");

    // Nothing leaves the block in the cycle after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule : cldec_checker

bind deflate_code_length_decoder cldec_checker u_cldec_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);
`default_nettype wire
